FILE: rtl/rwrs_pkg.sv
// shared types and constants for the rank weighted roulette selector
// no dependencies; used by rank_weighted_roulette_selector_top

package rwrs_pkg;

	localparam int POPULATION   = 64;
	localparam int RESULT_LIMIT = 64;

	localparam int IDX_W   = $clog2(POPULATION);
	localparam int CNT_W   = $clog2(POPULATION + 1);
	localparam int FIT_W   = 32;
	localparam int DRAW_W  = 24;
	localparam int IND_W   = 8;
	localparam int ELITE_W = 7;

	localparam logic [ELITE_W-1:0] ELITE_RESET = ELITE_W'(6);
	localparam int ELITE_MAX = (POPULATION < RESULT_LIMIT) ? POPULATION : RESULT_LIMIT;

	// sum of r*r over all ranks
	localparam int WEIGHT_TOTAL = ((POPULATION - 1) * POPULATION * (2 * POPULATION - 1)) / 6;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_DRAW = 1'b1;

	typedef enum logic [1:0] {
		ERR_OK       = 2'd0,
		ERR_RANGE    = 2'd1,
		ERR_UNRANKED = 2'd2
	} err_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SORT_KEY,
		S_SORT_SCAN,
		S_SORT_DRAIN,
		S_SORT_WR,
		S_ELITE_RD,
		S_ELITE_OUT,
		S_WALK,
		S_DRAW_OUT
	} state_t;

endpackage

FILE: rtl/rank_weighted_roulette_selector_top.sv
// rank weighted roulette selector: fitness and rank memories with sort, elite and draw sequencer
// depends on rwrs_pkg
//
// a load that does not complete the population only writes the fitness memory
// the completing load sorts, counting for each individual the entries below it (one fitness
// memory read a cycle), then emits each elite through a rank memory read; output can stall it
// a draw walks cumulative squared ranks until the sum passes it; out of range takes the top rank
// reset clears control state, load count and ranked flag, sets elite count to 6; memories hold
// garbage until loaded and need no clearing pass

module rank_weighted_roulette_selector_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rwrs_pkg::ELITE_W-1:0]  cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [rwrs_pkg::FIT_W-1:0]    fitness_value,
	input  logic [rwrs_pkg::DRAW_W-1:0]   draw_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rwrs_pkg::IND_W-1:0]    individual,
	output logic                          is_elite,
	output logic                          last,
	output logic [1:0]                    error
);

	localparam int P      = rwrs_pkg::POPULATION;
	localparam int IDX_W  = rwrs_pkg::IDX_W;
	localparam int CNT_W  = rwrs_pkg::CNT_W;
	localparam int FIT_W  = rwrs_pkg::FIT_W;
	localparam int DRAW_W = rwrs_pkg::DRAW_W;
	localparam int IND_W  = rwrs_pkg::IND_W;
	localparam int ELT_W  = rwrs_pkg::ELITE_W;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(P - 1);

	rwrs_pkg::state_t state_q, state_d;

	// control registers
	logic [CNT_W-1:0] load_count_q;
	logic             ranked_q;
	logic [ELT_W-1:0] elite_count_q;
	logic             out_valid_q;
	logic             cmp_valid_s1;

	// datapath registers
	logic [IDX_W-1:0]  i_q, j_q, pos_q, r_q, j_s1;
	logic [FIT_W-1:0]  key_q;
	logic [ELT_W-1:0]  n_q;
	logic [DRAW_W-1:0] draw_q, sum_q;
	rwrs_pkg::err_t    err_q;
	logic [IND_W-1:0]  out_ind_q;
	logic              out_elite_q, out_last_q;
	rwrs_pkg::err_t    out_err_q;

	// memories
	logic [FIT_W-1:0] fit_mem [P];
	logic [IND_W-1:0] rank_mem [P];
	logic [FIT_W-1:0] fit_rd_s1;
	logic [IND_W-1:0] rank_rd_s1;

	logic             fit_we, rank_we, rank_re;
	logic [IDX_W-1:0] fit_waddr, fit_raddr, rank_raddr;
	logic             out_load, slot_free;
	logic             load_wrap, load_last, accept;
	logic             below;
	logic [ELT_W-1:0] elite_total;
	logic             elite_last;
	logic [2*IDX_W-1:0]  r_sq;
	logic [DRAW_W-1:0]   sum_next;
	logic [IND_W-1:0]    out_ind_d;
	logic                out_elite_d, out_last_d;
	rwrs_pkg::err_t      out_err_d;

	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign load_wrap = (load_count_q == CNT_W'(P));
	assign load_last = !load_wrap && (load_count_q == CNT_W'(P - 1));
	assign fit_waddr = load_wrap ? '0 : load_count_q[IDX_W-1:0];

	// stable order: on equal fitness the earlier individual ranks lower
	assign below = ($signed(fit_rd_s1) < $signed(key_q))
		|| ((fit_rd_s1 == key_q) && (j_s1 < i_q));

	assign elite_total = (elite_count_q > ELT_W'(rwrs_pkg::ELITE_MAX))
		? ELT_W'(rwrs_pkg::ELITE_MAX) : elite_count_q;
	assign elite_last  = ((n_q + ELT_W'(1)) == elite_total);

	assign r_sq     = r_q * r_q;
	assign sum_next = sum_q + DRAW_W'(r_sq);

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		fit_we      = 1'b0;
		fit_raddr   = '0;
		rank_we     = 1'b0;
		rank_re     = 1'b0;
		rank_raddr  = '0;
		out_load    = 1'b0;
		out_ind_d   = rank_rd_s1;
		out_elite_d = 1'b0;
		out_last_d  = 1'b1;
		out_err_d   = err_q;
		case (state_q)
			rwrs_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (kind == rwrs_pkg::KIND_LOAD) begin
						fit_we = 1'b1;
						if (load_last) state_d = rwrs_pkg::S_SORT_KEY;
					end else if (!ranked_q) begin
						state_d = rwrs_pkg::S_DRAW_OUT;
					end else begin
						state_d = rwrs_pkg::S_WALK;
					end
				end
			end
			rwrs_pkg::S_SORT_KEY: begin
				fit_raddr = i_q;
				state_d   = rwrs_pkg::S_SORT_SCAN;
			end
			rwrs_pkg::S_SORT_SCAN: begin
				fit_raddr = j_q;
				if (j_q == IDX_LAST) state_d = rwrs_pkg::S_SORT_DRAIN;
			end
			rwrs_pkg::S_SORT_DRAIN: begin
				state_d = rwrs_pkg::S_SORT_WR;
			end
			rwrs_pkg::S_SORT_WR: begin
				rank_we = 1'b1;
				if (i_q != IDX_LAST) begin
					state_d = rwrs_pkg::S_SORT_KEY;
				end else if (elite_total == '0) begin
					state_d = rwrs_pkg::S_IDLE;
				end else begin
					state_d = rwrs_pkg::S_ELITE_RD;
				end
			end
			rwrs_pkg::S_ELITE_RD: begin
				rank_re    = 1'b1;
				rank_raddr = IDX_LAST - IDX_W'(n_q);
				state_d    = rwrs_pkg::S_ELITE_OUT;
			end
			rwrs_pkg::S_ELITE_OUT: begin
				out_elite_d = 1'b1;
				out_last_d  = elite_last;
				out_err_d   = rwrs_pkg::ERR_OK;
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = elite_last ? rwrs_pkg::S_IDLE : rwrs_pkg::S_ELITE_RD;
				end
			end
			rwrs_pkg::S_WALK: begin
				if (err_q == rwrs_pkg::ERR_RANGE) begin
					rank_re    = 1'b1;
					rank_raddr = IDX_LAST;
					state_d    = rwrs_pkg::S_DRAW_OUT;
				end else if ((sum_next > draw_q) || (r_q == IDX_LAST)) begin
					rank_re    = 1'b1;
					rank_raddr = r_q;
					state_d    = rwrs_pkg::S_DRAW_OUT;
				end
			end
			rwrs_pkg::S_DRAW_OUT: begin
				if (err_q == rwrs_pkg::ERR_UNRANKED) out_ind_d = '0;
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = rwrs_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rwrs_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rwrs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q  <= '0;
			ranked_q      <= 1'b0;
			elite_count_q <= rwrs_pkg::ELITE_RESET;
			out_valid_q   <= 1'b0;
			cmp_valid_s1  <= 1'b0;
		end else begin
			if (cfg_we) elite_count_q <= cfg_wdata;
			if (accept && (kind == rwrs_pkg::KIND_LOAD)) begin
				if (load_wrap) begin
					load_count_q <= CNT_W'(1);
					ranked_q     <= 1'b0;
				end else begin
					load_count_q <= load_count_q + CNT_W'(1);
				end
			end
			if ((state_q == rwrs_pkg::S_SORT_WR) && (i_q == IDX_LAST)) ranked_q <= 1'b1;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			cmp_valid_s1 <= (state_q == rwrs_pkg::S_SORT_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		j_s1 <= j_q;
		if (accept && (kind == rwrs_pkg::KIND_LOAD)) i_q <= '0;
		if (accept && (kind == rwrs_pkg::KIND_DRAW)) begin
			draw_q <= draw_value;
			r_q    <= '0;
			sum_q  <= '0;
			if (!ranked_q) begin
				err_q <= rwrs_pkg::ERR_UNRANKED;
			end else if (draw_value >= DRAW_W'(rwrs_pkg::WEIGHT_TOTAL)) begin
				err_q <= rwrs_pkg::ERR_RANGE;
			end else begin
				err_q <= rwrs_pkg::ERR_OK;
			end
		end
		if (state_q == rwrs_pkg::S_SORT_KEY) begin
			pos_q <= '0;
			j_q   <= '0;
		end else if (cmp_valid_s1 && below) begin
			pos_q <= pos_q + IDX_W'(1);
		end
		if (state_q == rwrs_pkg::S_SORT_SCAN) begin
			j_q <= j_q + IDX_W'(1);
			// read data still holds the key fetched in SORT_KEY
			if (j_q == '0) key_q <= fit_rd_s1;
		end
		if (state_q == rwrs_pkg::S_SORT_WR) begin
			i_q <= i_q + IDX_W'(1);
			n_q <= '0;
		end
		if (state_q == rwrs_pkg::S_WALK) begin
			r_q   <= r_q + IDX_W'(1);
			sum_q <= sum_next;
		end
		if ((state_q == rwrs_pkg::S_ELITE_OUT) && slot_free) n_q <= n_q + ELT_W'(1);
		if (out_load) begin
			out_ind_q   <= out_ind_d;
			out_elite_q <= out_elite_d;
			out_last_q  <= out_last_d;
			out_err_q   <= out_err_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fit_we) fit_mem[fit_waddr] <= fitness_value;
		fit_rd_s1 <= fit_mem[fit_raddr];
	end

	always_ff @(posedge clk) begin
		if (rank_we) rank_mem[pos_q] <= IND_W'(i_q);
		if (rank_re) rank_rd_s1 <= rank_mem[rank_raddr];
	end

	assign out_valid  = out_valid_q;
	assign individual = out_ind_q;
	assign is_elite   = out_elite_q;
	assign last       = out_last_q;
	assign error      = out_err_q;

	a_elite_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_elite_q) |-> (out_err_q == rwrs_pkg::ERR_OK))
		else $error("elite item carries an error code");

	a_unranked_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_err_q == rwrs_pkg::ERR_UNRANKED)) |->
		((out_ind_q == '0) && !out_elite_q && out_last_q))
		else $error("unranked draw answer is malformed");

	a_sort_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (kind == rwrs_pkg::KIND_LOAD) && load_last) |=>
		((state_q == rwrs_pkg::S_SORT_KEY) && (load_count_q == CNT_W'(P))))
		else $error("completing load did not start the sort");

	a_ranked_full: assert property (@(posedge clk) disable iff (!arst_n)
		ranked_q |-> (load_count_q == CNT_W'(P)))
		else $error("ranked with an incomplete population");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> slot_free)
		else $error("output register overwritten while held");

endmodule

FILE: dv/rank_weighted_roulette_selector_top_test.sv
// self-checking bench for rank_weighted_roulette_selector_top: population loads, elite lists, draws
// depends on rwrs_pkg and the rtl top; carries its own ranking and roulette predictor
`timescale 1ns / 1ps

module rank_weighted_roulette_selector_top_test;

	localparam int SETTLE_CYCLES = rwrs_pkg::POPULATION * (rwrs_pkg::POPULATION + 3)
		+ 2 * rwrs_pkg::POPULATION + 16;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic                        kind;
		logic [rwrs_pkg::FIT_W-1:0]  fitness;
		logic [rwrs_pkg::DRAW_W-1:0] draw;
	} pop_item_t;

	typedef struct packed {
		logic [rwrs_pkg::IND_W-1:0] individual;
		logic                       is_elite;
		logic                       last;
		rwrs_pkg::err_t             error;
	} selection_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [rwrs_pkg::ELITE_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = rwrs_pkg::KIND_LOAD;
	logic [rwrs_pkg::FIT_W-1:0] fitness_value = '0;
	logic [rwrs_pkg::DRAW_W-1:0] draw_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [rwrs_pkg::IND_W-1:0] individual;
	logic is_elite;
	logic last;
	logic [1:0] error;

	// predictor state
	logic [rwrs_pkg::FIT_W-1:0] fitness_img [rwrs_pkg::POPULATION];
	logic [rwrs_pkg::IND_W-1:0] rank_img [rwrs_pkg::POPULATION];
	int loads_seen = 0;
	bit ranked_now = 1'b0;
	logic [rwrs_pkg::ELITE_W-1:0] elite_setting = rwrs_pkg::ELITE_RESET;

	pop_item_t items_pending [$];
	selection_t selections_due [$];
	pop_item_t nxt;
	selection_t got, want;
	int items_queued = 0;
	int items_accepted = 0;
	int mismatches = 0;
	int send_gap = 0;
	int ready_gap = 0;
	bit no_idle = 1'b0;

	rank_weighted_roulette_selector_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.fitness_value(fitness_value),
		.draw_value   (draw_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.individual   (individual),
		.is_elite     (is_elite),
		.last         (last),
		.error        (error)
	);

	always #5 clk = ~clk;

	function automatic int squares_upto(int r);
		return r * (r + 1) * (2 * r + 1) / 6;
	endfunction

	// stable insertion sort, ascending by signed fitness
	function automatic void rank_population();
		int j;
		for (int i = 0; i < rwrs_pkg::POPULATION; i++) begin
			j = i;
			while (j > 0 && $signed(fitness_img[rank_img[j-1]]) > $signed(fitness_img[i])) begin
				rank_img[j] = rank_img[j-1];
				j--;
			end
			rank_img[j] = rwrs_pkg::IND_W'(i);
		end
	endfunction

	function automatic void predict_selection(pop_item_t it);
		int count;
		int pick;
		int sum;
		selection_t s;
		if (it.kind == rwrs_pkg::KIND_LOAD) begin
			if (loads_seen >= rwrs_pkg::POPULATION) begin
				loads_seen = 0;
				ranked_now = 1'b0;
			end
			fitness_img[loads_seen] = it.fitness;
			loads_seen++;
			if (loads_seen < rwrs_pkg::POPULATION)
				return;
			rank_population();
			ranked_now = 1'b1;
			count = (int'(elite_setting) > rwrs_pkg::ELITE_MAX)
				? rwrs_pkg::ELITE_MAX : int'(elite_setting);
			for (int n = 0; n < count; n++) begin
				s.individual = rank_img[rwrs_pkg::POPULATION-1-n];
				s.is_elite = 1'b1;
				s.last = (n + 1 == count);
				s.error = rwrs_pkg::ERR_OK;
				selections_due.push_back(s);
			end
		end else begin
			s.is_elite = 1'b0;
			s.last = 1'b1;
			if (!ranked_now) begin
				s.individual = '0;
				s.error = rwrs_pkg::ERR_UNRANKED;
			end else if (int'(it.draw) >= rwrs_pkg::WEIGHT_TOTAL) begin
				s.individual = rank_img[rwrs_pkg::POPULATION-1];
				s.error = rwrs_pkg::ERR_RANGE;
			end else begin
				// smallest rank whose running sum of squares passes the draw
				sum = 0;
				pick = rwrs_pkg::POPULATION - 1;
				for (int r = 0; r < rwrs_pkg::POPULATION; r++) begin
					sum += r * r;
					if (sum > int'(it.draw)) begin
						pick = r;
						break;
					end
				end
				s.individual = rank_img[pick];
				s.error = rwrs_pkg::ERR_OK;
			end
			selections_due.push_back(s);
		end
	endfunction

	function automatic logic [rwrs_pkg::FIT_W-1:0] pick_fitness();
		case ($urandom_range(0, 5))
			0: return rwrs_pkg::FIT_W'($urandom_range(0, 6)) - rwrs_pkg::FIT_W'(3);
			1: return 32'h8000_0000 + rwrs_pkg::FIT_W'($urandom_range(0, 2));
			2: return 32'h7FFF_FFFF - rwrs_pkg::FIT_W'($urandom_range(0, 2));
			default: return rwrs_pkg::FIT_W'($urandom);
		endcase
	endfunction

	function automatic logic [rwrs_pkg::DRAW_W-1:0] pick_draw();
		int r;
		r = $urandom_range(1, rwrs_pkg::POPULATION - 1);
		case ($urandom_range(0, 9))
			0, 1: return rwrs_pkg::DRAW_W'($urandom);
			2: return rwrs_pkg::DRAW_W'(squares_upto(r) - $urandom_range(0, 1));
			default: return rwrs_pkg::DRAW_W'($urandom_range(0, rwrs_pkg::WEIGHT_TOTAL - 1));
		endcase
	endfunction

	task automatic push_load(logic [rwrs_pkg::FIT_W-1:0] v);
		pop_item_t it;
		it.kind = rwrs_pkg::KIND_LOAD;
		it.fitness = v;
		it.draw = rwrs_pkg::DRAW_W'($urandom);
		items_pending.push_back(it);
		items_queued++;
	endtask

	task automatic push_draw(logic [rwrs_pkg::DRAW_W-1:0] d);
		pop_item_t it;
		it.kind = rwrs_pkg::KIND_DRAW;
		it.fitness = rwrs_pkg::FIT_W'($urandom);
		it.draw = d;
		items_pending.push_back(it);
		items_queued++;
	endtask

	task automatic random_population(int n_after);
		for (int i = 0; i < rwrs_pkg::POPULATION; i++) begin
			push_load(pick_fitness());
			// occasional draws interleaved with the loads of a new population
			if ($urandom_range(0, 15) == 0)
				push_draw(pick_draw());
		end
		repeat (n_after) push_draw(pick_draw());
	endtask

	// hold off until every item is in and every result is out, then let the design settle
	task automatic wait_drained();
		while (items_accepted != items_queued || selections_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_elite(logic [rwrs_pkg::ELITE_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		elite_setting = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else if (!in_valid || in_ready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (items_pending.size() != 0 && !no_idle && $urandom_range(0, 5) == 0) begin
				send_gap <= $urandom_range(0, 13);
				in_valid <= 1'b0;
			end else if (items_pending.size() != 0) begin
				nxt = items_pending.pop_front();
				in_valid <= 1'b1;
				kind <= nxt.kind;
				fitness_value <= nxt.fitness;
				draw_value <= nxt.draw;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			predict_selection('{kind, fitness_value, draw_value});
			items_accepted++;
		end
	end

	// monitor and result-side backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_gap <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got.individual = individual;
				got.is_elite = is_elite;
				got.last = last;
				got.error = rwrs_pkg::err_t'(error);
				if (selections_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result: individual %0d elite %0b last %0b error %0d",
							got.individual, got.is_elite, got.last, got.error);
				end else begin
					want = selections_due.pop_front();
					if (got.individual !== want.individual || got.is_elite !== want.is_elite ||
						got.last !== want.last || got.error !== want.error) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display({"result mismatch: expected ind %0d elite %0b last %0b ",
								"err %0d, got ind %0d elite %0b last %0b err %0d"},
								want.individual, want.is_elite, want.last, want.error,
								got.individual, got.is_elite, got.last, got.error);
					end
				end
			end
			if (ready_gap > 0) begin
				ready_gap <= ready_gap - 1;
				out_ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				ready_gap <= $urandom_range(0, 13);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// draws before any ranking
		push_draw('0);
		push_draw('1);

		// extremes and ties in the first population, elite count at its reset value
		for (int i = 0; i < rwrs_pkg::POPULATION; i++) begin
			case (i)
				0, 8: push_load(32'h8000_0000);
				1, 9: push_load(32'h7FFF_FFFF);
				2, 3, 4, 5: push_load('0);
				6: push_load('1);
				7: push_load(32'd1);
				default: push_load(pick_fitness());
			endcase
			if (i == 20)
				push_draw(rwrs_pkg::DRAW_W'(rwrs_pkg::WEIGHT_TOTAL));
		end
		push_draw('0);
		push_draw(rwrs_pkg::DRAW_W'(1));
		push_draw(rwrs_pkg::DRAW_W'(4));
		push_draw(rwrs_pkg::DRAW_W'(5));
		push_draw(rwrs_pkg::DRAW_W'(rwrs_pkg::WEIGHT_TOTAL - 1));
		push_draw(rwrs_pkg::DRAW_W'(rwrs_pkg::WEIGHT_TOTAL));
		push_draw('1);
		push_draw(24'h555555);
		wait_drained();
		repeat (10) push_draw(pick_draw());
		wait_drained();

		write_elite(7'd127);
		random_population(12);
		wait_drained();

		// zero elites: the completing load answers nothing
		write_elite(7'd0);
		random_population(12);
		wait_drained();

		no_idle = 1'b1;
		write_elite(7'd1);
		random_population(12);
		wait_drained();

		if (mismatches == 0 && selections_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/rwrs_pkg.sv
rtl/rank_weighted_roulette_selector_top.sv
dv/rank_weighted_roulette_selector_top_test.sv
